### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types for the double-ended queue
// Word layouts, action and status codes, and the control word broadcast to
// the chain of storage cells.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Default number of entries
   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   // Action codes carried in the request word
   typedef enum logic [2:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_DUMP       = 3'd4
   } action_type;

   // Status codes carried in the response word
   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Request word
   typedef struct packed {
      logic [2:0]               action;
      logic signed [DATA_W-1:0] entry_value;
   } req_type;

   // Response word
   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] read_value;
      logic                     last_item;
   } rsp_type;

   // Per-cycle operation applied by every cell of the chain
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_FRONT,
      OP_ROTATE
   } cell_op_type;

   // Broadcast control word for the chain
   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

   // Controller states
   typedef enum logic {
      CS_IDLE,
      CS_DUMP
   } ctl_state_type;

endpackage

### rtl/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell: one storage slot of the queue chain
// Holds one entry; position 0 is the front. Each cycle the slot keeps its
// entry, loads the pushed value, or takes a neighbor's entry or the front entry.
// ----------------------------------------------------------------------------
module deq_cell #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   parameter int INDEX = 0
) (
   input  logic                              clock,
   input  deq_pkg::cell_ctrl_type            ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]        count,
   input  logic signed [deq_pkg::DATA_W-1:0] left_q,
   input  logic signed [deq_pkg::DATA_W-1:0] right_q,
   input  logic signed [deq_pkg::DATA_W-1:0] head_q,
   output logic signed [deq_pkg::DATA_W-1:0] data_q
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic signed [deq_pkg::DATA_W-1:0] data_ff;
   logic signed [deq_pkg::DATA_W-1:0] data_in;
   logic [CW-1:0]                     count_m1;

   assign count_m1 = count - CW'(1);

   // Next entry of this slot
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         deq_pkg::OP_HOLD: begin
            data_in = data_ff;
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (IDX == count) data_in = ctrl.value;
         end
         deq_pkg::OP_PUSH_FRONT: begin
            data_in = (INDEX == 0) ? ctrl.value : left_q;
         end
         deq_pkg::OP_POP_FRONT: begin
            data_in = right_q;
         end
         deq_pkg::OP_ROTATE: begin
            // front entry wraps to the back of the occupied part
            if (IDX == count_m1) data_in = head_q;
            else if (IDX < count_m1) data_in = right_q;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

### rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit entries
// Entries sit in a chain of DEPTH cells, front in cell 0. Push back, push
// front, pop back and pop front each return one status word; with the
// response consumer ready, one such request is taken every cycle. A dump
// emits one word per stored entry, front first, rotating the chain one
// place per emitted word (the front entry wraps to the back, so the
// contents are unchanged after the dump); new requests wait while a dump
// runs. An empty dump gives one empty status word. Action codes 5 to 7
// are taken and dropped with no response.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output deq_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   deq_pkg::ctl_state_type state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          dump_left_ff, dump_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type       rsp_data_ff, rsp_data_in;

   deq_pkg::cell_ctrl_type ctrl;
   logic                   out_free;
   logic                   accept;
   logic                   load_rsp;
   logic                   full;
   logic                   empty;

   logic signed [deq_pkg::DATA_W-1:0] cell_q [DEPTH];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == deq_pkg::CS_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == DEPTH_C);
   assign empty     = (count_ff == '0);

   // Request decode, dump sequencing and response build
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dump_left_in = dump_left_ff;
      load_rsp     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ctrl.op      = deq_pkg::OP_HOLD;
      ctrl.value   = req_data.entry_value;

      unique case (state_ff)
         deq_pkg::CS_IDLE: begin
            if (accept) begin
               rsp_data_in.status     = deq_pkg::STAT_DONE;
               rsp_data_in.read_value = '0;
               rsp_data_in.last_item  = 1'b1;
               unique case (req_data.action)
                  deq_pkg::ACT_PUSH_BACK, deq_pkg::ACT_PUSH_FRONT: begin
                     load_rsp = 1'b1;
                     if (full) begin
                        rsp_data_in.status = deq_pkg::STAT_FULL;
                     end else begin
                        ctrl.op  = (req_data.action == deq_pkg::ACT_PUSH_BACK)
                                   ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  deq_pkg::ACT_POP_BACK, deq_pkg::ACT_POP_FRONT: begin
                     load_rsp = 1'b1;
                     if (empty) begin
                        rsp_data_in.status = deq_pkg::STAT_EMPTY;
                     end else begin
                        if (req_data.action == deq_pkg::ACT_POP_FRONT)
                           ctrl.op = deq_pkg::OP_POP_FRONT;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  deq_pkg::ACT_DUMP: begin
                     if (empty) begin
                        load_rsp           = 1'b1;
                        rsp_data_in.status = deq_pkg::STAT_EMPTY;
                     end else begin
                        state_in     = deq_pkg::CS_DUMP;
                        dump_left_in = count_ff;
                     end
                  end
                  default: begin
                     load_rsp = 1'b0;
                  end
               endcase
            end
         end
         deq_pkg::CS_DUMP: begin
            // emit the front cell and rotate the chain one place
            if (out_free) begin
               load_rsp               = 1'b1;
               ctrl.op                = deq_pkg::OP_ROTATE;
               rsp_data_in.status     = deq_pkg::STAT_DONE;
               rsp_data_in.read_value = cell_q[0];
               rsp_data_in.last_item  = (dump_left_ff == CW'(1));
               dump_left_in           = dump_left_ff - CW'(1);
               if (dump_left_ff == CW'(1)) state_in = deq_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = deq_pkg::CS_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::CS_IDLE;
         count_ff     <= '0;
         dump_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_left_ff <= dump_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Chain of storage cells, cell 0 at the front
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [deq_pkg::DATA_W-1:0] left_w;
      logic signed [deq_pkg::DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_left
         assign left_w = cell_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = cell_q[i];
      end else begin : g_mid_right
         assign right_w = cell_q[i+1];
      end

      deq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .count   (count_ff),
         .left_q  (left_w),
         .right_q (right_w),
         .head_q  (cell_q[0]),
         .data_q  (cell_q[i])
      );
   end

   // Occupancy never exceeds the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above depth");

   // A running dump has words left and never more than are stored
   a_dump_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == deq_pkg::CS_DUMP) |-> (dump_left_ff != '0) && (dump_left_ff <= count_ff))
      else $error("dump counter out of range");

   // Count is unchanged while a dump runs
   a_dump_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == deq_pkg::CS_DUMP) |=> (count_ff == $past(count_ff)))
      else $error("count changed during dump");

   // Leaving the dump state follows the word marked last
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == deq_pkg::CS_DUMP) ##1 (state_ff == deq_pkg::CS_IDLE)
      |-> rsp_valid_ff && rsp_data_ff.last_item)
      else $error("dump ended without last word");

endmodule

### verif/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the double-ended queue
// Drives request words through the valid/ready port and tracks the store in
// a queue of its own. Every response word is checked against the expected
// words in arrival order. Directed runs cover the empty and full edges, front
// pushes and the dropped action codes. A stalled consumer forces the queue to
// back up, and random traffic then runs with idle gaps on both sides.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = deq_pkg::DEPTH_DEFAULT;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   deq_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   deq_pkg::rsp_type rsp_data;

   // Shadow of the store contents, front at index 0
   logic signed [deq_pkg::DATA_W-1:0] stored_entries[$];
   // Response words still owed by the block, oldest first
   deq_pkg::rsp_type                  expected_words[$];

   int               failure_count    = 0;
   bit               src_idle         = 1'b1;
   bit               sink_idle        = 1'b1;
   int               sink_hold_cycles = 0;
   deq_pkg::rsp_type rsp_seen;

   double_ended_queue #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic void report_failure(input string msg);
      failure_count++;
      if (failure_count <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // Update the shadow store for one accepted word and queue its responses
   function automatic void apply_action(input deq_pkg::req_type w);
      deq_pkg::rsp_type r;
      int               n;
      n           = stored_entries.size();
      r.status    = deq_pkg::STAT_DONE;
      r.read_value = '0;
      r.last_item = 1'b1;
      unique case (w.action)
         deq_pkg::ACT_PUSH_BACK, deq_pkg::ACT_PUSH_FRONT: begin
            if (n >= DEPTH) begin
               r.status = deq_pkg::STAT_FULL;
            end else if (w.action == deq_pkg::ACT_PUSH_BACK) begin
               stored_entries.push_back(w.entry_value);
            end else begin
               stored_entries.push_front(w.entry_value);
            end
            expected_words.push_back(r);
         end
         deq_pkg::ACT_POP_BACK, deq_pkg::ACT_POP_FRONT: begin
            if (n == 0) begin
               r.status = deq_pkg::STAT_EMPTY;
            end else if (w.action == deq_pkg::ACT_POP_BACK) begin
               void'(stored_entries.pop_back());
            end else begin
               void'(stored_entries.pop_front());
            end
            expected_words.push_back(r);
         end
         deq_pkg::ACT_DUMP: begin
            if (n == 0) begin
               r.status = deq_pkg::STAT_EMPTY;
               expected_words.push_back(r);
            end else begin
               // front to back, last word flagged
               for (int i = 0; i < n; i++) begin
                  r.read_value = stored_entries[i];
                  r.last_item  = (i == n - 1);
                  expected_words.push_back(r);
               end
            end
         end
         default: ; // unused codes: dropped, nothing owed
      endcase
   endfunction

   function automatic void check_word(input deq_pkg::rsp_type got);
      deq_pkg::rsp_type want;
      if (expected_words.size() == 0) begin
         report_failure($sformatf("unexpected word: status %0d value %0d last %0d",
                                  got.status, got.read_value, got.last_item));
         return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status || got.read_value !== want.read_value ||
          got.last_item !== want.last_item) begin
         report_failure($sformatf(
            "mismatch: expected status %0d value %0d last %0d, got %0d %0d %0d",
            want.status, want.read_value, want.last_item,
            got.status, got.read_value, got.last_item));
      end
   endfunction

   // Response checker: capture at the edge, compare once this edge's
   // predictions are in
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen = rsp_data;
         #1;
         check_word(rsp_seen);
      end
   end

   // Response consumer: random stalls per word, plus long hold-offs on request
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         gap = sink_idle ? $urandom_range(0, 13) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock);
         while (!(rsp_valid && rsp_ready) && sink_hold_cycles == 0);
      end
   end

   // Offer one request word and wait for it to be taken
   task automatic send_word(input logic [2:0] act,
                            input logic signed [deq_pkg::DATA_W-1:0] value);
      int gap;
      gap = src_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{action: act, entry_value: value};
      do @(posedge clock); while (!req_ready);
      apply_action(req_data);
   endtask

   task automatic wait_drained();
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [deq_pkg::DATA_W-1:0] pick_value();
      unique case ($urandom_range(0, 7))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Pops and dump on a store that has never been written
   task automatic test_empty_store();
      send_word(deq_pkg::ACT_POP_BACK, 32'sh7fff_ffff);
      send_word(deq_pkg::ACT_POP_FRONT, 32'sh8000_0000);
      send_word(deq_pkg::ACT_DUMP, '1);
   endtask

   // Fill from both ends, refuse pushes when full, pops at both ends,
   // dumps around them, then the dropped codes
   task automatic test_fill_and_wrap();
      logic signed [deq_pkg::DATA_W-1:0] corner_vals [8] = '{
         32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff,
         32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 32'sh0000_ffff};
      for (int i = 0; i < 8; i++) begin
         send_word(deq_pkg::ACT_PUSH_BACK, corner_vals[i]);
      end
      // front pushes shift the chain toward the back
      for (int i = 0; i < DEPTH - 8; i++) begin
         send_word(deq_pkg::ACT_PUSH_FRONT, ~corner_vals[i % 8]);
      end
      send_word(deq_pkg::ACT_PUSH_BACK, 32'sh1234_5678);
      send_word(deq_pkg::ACT_PUSH_FRONT, 32'sh8765_4321);
      send_word(deq_pkg::ACT_DUMP, '0);
      // pop back must pull the back end in by one
      send_word(deq_pkg::ACT_POP_BACK, '0);
      send_word(deq_pkg::ACT_POP_FRONT, '0);
      send_word(deq_pkg::ACT_DUMP, '0);
      for (int c = deq_pkg::ACT_DUMP + 1; c < 8; c++) begin
         send_word(3'(c), $urandom);
      end
   endtask

   // Consumer stalls while requests keep coming, so the block backs up
   task automatic test_backpressure();
      src_idle         = 1'b0;
      sink_hold_cycles = 150;
      for (int i = 0; i < 40; i++) begin
         if (i == 20) begin
            send_word(deq_pkg::ACT_DUMP, '0);
         end else if (i % 5 == 4) begin
            send_word(deq_pkg::ACT_POP_FRONT, '0);
         end else begin
            send_word(deq_pkg::ACT_PUSH_BACK, $urandom);
         end
      end
      // sender stays quiet until every word is back
      req_valid <= 1'b0;
      wait_drained();
   endtask

   // Random mix in runs of fill-heavy, balanced and drain-heavy traffic
   task automatic test_random_traffic(input int n_items);
      int         sent;
      int         run_left;
      int         push_bias;
      int         r;
      int         n;
      bit         paused;
      logic [2:0] act;
      sent      = 0;
      run_left  = 0;
      push_bias = 50;
      paused    = 1'b0;
      while (sent < n_items) begin
         if (run_left == 0) begin
            run_left  = $urandom_range(8, 20);
            push_bias = 25 * $urandom_range(1, 3);
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
         end
         if (!paused && sent >= n_items / 2) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            wait_drained();
         end
         n = stored_entries.size();
         if ($urandom_range(0, 99) < 3) begin
            // dropped code, not counted
            send_word(deq_pkg::ACT_DUMP + 3'($urandom_range(1, 3)), $urandom);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
               act = deq_pkg::ACT_DUMP;
            end else if (n >= DEPTH ? r < 25 : (n == 0 ? r < 80 : r < 10 + push_bias)) begin
               act = $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
            end else begin
               act = $urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
            end
            send_word(act, pick_value());
            sent++;
            run_left--;
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_store();
      test_fill_and_wrap();
      test_backpressure();
      test_random_traffic(105);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DEPTH + 10) @(posedge clock);
      if (expected_words.size() != 0) begin
         report_failure($sformatf("%0d expected words never arrived", expected_words.size()));
      end
      if (failure_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
